// ----- rtl/core/urtm_pkg.sv -----
// ----------------------------------------------------------------------------
// urtm_pkg
// Shared types, widths and constants for the ultrasonic ranger with
// single, mean-of-three and trimmed-mean-of-five readings.
// ----------------------------------------------------------------------------
package urtm_pkg;

  localparam int TICK_W = 20;   // tick counters and timeout
  localparam int TRIG_W = 8;    // trigger and clear lengths
  localparam int DIST_W = 15;   // distance in cm
  localparam int SUM_W  = 17;   // sum of up to five samples
  localparam int IDX_W  = 3;    // sample index
  localparam int FRAC_W = 10;   // remainder of us*17 mod 1000
  localparam int FUNC_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TICK_W;

  // cm = floor(us * 17 / 1000), tracked one tick at a time
  localparam logic [FRAC_W:0] CM_STEP = (FRAC_W+1)'(17);
  localparam logic [FRAC_W:0] CM_BASE = (FRAC_W+1)'(1000);

  // x / 3 == (x * ceil(2^17 / 3)) >> 17 for every 17-bit x
  localparam int DIV3_MW    = 16;
  localparam int DIV3_SHIFT = 17;
  localparam logic [DIV3_MW-1:0] DIV3_MULT = DIV3_MW'(43691);

  localparam logic [TICK_W-1:0] TIMEOUT_RST = TICK_W'(1000000);
  localparam logic [TRIG_W-1:0] TRIGGER_RST = TRIG_W'(10);
  localparam logic [TRIG_W-1:0] CLEAR_RST   = TRIG_W'(2);

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR   = CFG_IDX_W'(2);

  localparam logic [FUNC_W-1:0] FUNC_SINGLE = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] FUNC_MEAN3  = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] FUNC_TRIM5  = FUNC_W'(2);

  localparam logic [IDX_W-1:0] SAMPLES_SINGLE = IDX_W'(1);
  localparam logic [IDX_W-1:0] SAMPLES_MEAN3  = IDX_W'(3);
  localparam logic [IDX_W-1:0] SAMPLES_TRIM5  = IDX_W'(5);

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_CLEAR     = 6'b000010,
    PH_TRIG      = 6'b000100,
    PH_WAIT_LOW  = 6'b001000,
    PH_WAIT_RISE = 6'b010000,
    PH_HIGH      = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0] timeout_us;
    logic [TRIG_W-1:0] trigger_us;
    logic [TRIG_W-1:0] clear_us;
  } cfg_t;

  typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    logic [DIST_W-1:0] distance_cm;
  } result_t;

  function automatic logic [DIST_W-1:0] div3(input logic [SUM_W-1:0] x);
    logic [SUM_W+DIV3_MW-1:0] prod;
    prod = {{DIV3_MW{1'b0}}, x} * {{SUM_W{1'b0}}, DIV3_MULT};
    return prod[DIV3_SHIFT +: DIST_W];
  endfunction

endpackage

// ----- rtl/core/urtm_ctrl.sv -----
// ----------------------------------------------------------------------------
// urtm_ctrl
// Measurement sequencer: trigger timing, echo timing, sample accumulation.
// State advances by one tick whenever step is high; res is the tick's result.
// ----------------------------------------------------------------------------
module urtm_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic                        start_req,
  input  logic [urtm_pkg::FUNC_W-1:0] func,
  input  logic                        echo_level,
  input  urtm_pkg::cfg_t              cfg,
  output urtm_pkg::result_t           res
);
  import urtm_pkg::*;

  phase_t              phase, phase_next;
  logic [TICK_W-1:0]   tick_count, tick_count_next;
  logic [DIST_W-1:0]   pulse_cm, pulse_cm_next;
  logic [FRAC_W-1:0]   pulse_frac, pulse_frac_next;
  logic [IDX_W-1:0]    sample_index, sample_index_next;
  logic [FUNC_W-1:0]   mode, mode_next;
  logic [SUM_W-1:0]    running_sum, running_sum_next;
  logic [DIST_W-1:0]   smallest, smallest_next;
  logic [DIST_W-1:0]   largest, largest_next;

  logic [TICK_W-1:0]   tick_inc;
  logic [FRAC_W:0]     frac_add;
  logic                finished;
  logic [DIST_W-1:0]   sample_cm;
  logic [IDX_W-1:0]    idx_inc;
  logic [IDX_W-1:0]    needed;
  logic [DIST_W:0]     drop;
  logic [SUM_W-1:0]    rest;

  assign tick_inc = tick_count + TICK_W'(1);
  assign frac_add = {1'b0, pulse_frac} + CM_STEP;
  assign idx_inc  = sample_index + IDX_W'(1);

  always_comb begin
    case (mode)
      FUNC_MEAN3: needed = SAMPLES_MEAN3;
      FUNC_TRIM5: needed = SAMPLES_TRIM5;
      default:    needed = SAMPLES_SINGLE;
    endcase
  end

  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    pulse_cm_next     = pulse_cm;
    pulse_frac_next   = pulse_frac;
    sample_index_next = sample_index;
    mode_next         = mode;
    running_sum_next  = running_sum;
    smallest_next     = smallest;
    largest_next      = largest;
    finished          = 1'b0;
    sample_cm         = '0;
    drop              = '0;
    rest              = '0;
    res               = '0;
    res.busy_res      = 1'b1;

    unique case (phase)
      PH_CLEAR: begin
        tick_count_next = tick_inc;
        if (tick_inc >= {{(TICK_W-TRIG_W){1'b0}}, cfg.clear_us}) begin
          tick_count_next = '0;
          phase_next      = PH_TRIG;
        end
      end
      PH_TRIG: begin
        res.trigger_level = 1'b1;
        tick_count_next   = tick_inc;
        if (tick_inc >= {{(TICK_W-TRIG_W){1'b0}}, cfg.trigger_us}) begin
          tick_count_next = '0;
          phase_next      = PH_WAIT_LOW;
        end
      end
      PH_WAIT_LOW, PH_WAIT_RISE, PH_HIGH: begin
        if (phase == PH_WAIT_LOW) begin
          if (!echo_level) phase_next = PH_WAIT_RISE;
        end else if (phase == PH_WAIT_RISE) begin
          if (echo_level) begin
            // first high tick: pulse length 1
            phase_next      = PH_HIGH;
            pulse_cm_next   = '0;
            pulse_frac_next = CM_STEP[FRAC_W-1:0];
          end
        end else if (echo_level) begin
          if (frac_add >= CM_BASE) begin
            pulse_frac_next = FRAC_W'(frac_add - CM_BASE);
            pulse_cm_next   = pulse_cm + DIST_W'(1);
          end else begin
            pulse_frac_next = frac_add[FRAC_W-1:0];
          end
        end else begin
          finished  = 1'b1;
          sample_cm = pulse_cm;
        end
        if (!finished) begin
          tick_count_next = tick_inc;
          if (tick_inc >= cfg.timeout_us) begin
            finished  = 1'b1;
            sample_cm = '0;
          end
        end
      end
      PH_IDLE: begin
        res.busy_res = 1'b0;
        if (start_req) begin
          res.busy_res      = 1'b1;
          mode_next         = (func == FUNC_MEAN3 || func == FUNC_TRIM5) ? func : FUNC_SINGLE;
          sample_index_next = '0;
          running_sum_next  = '0;
          smallest_next     = '0;
          largest_next      = '0;
          pulse_cm_next     = '0;
          pulse_frac_next   = '0;
          tick_count_next   = '0;
          phase_next        = (cfg.clear_us == '0) ? PH_TRIG : PH_CLEAR;
        end
      end
      default: begin
        res.busy_res = 1'b0;
        phase_next   = PH_IDLE;
      end
    endcase

    if (finished) begin
      if (sample_index == '0 || sample_cm > largest) largest_next = sample_cm;
      if (sample_index == '0 || sample_cm < smallest) smallest_next = sample_cm;
      running_sum_next  = running_sum + {{(SUM_W-DIST_W){1'b0}}, sample_cm};
      sample_index_next = idx_inc;
      if (idx_inc >= needed) begin
        drop = {1'b0, largest_next} + {1'b0, smallest_next};
        rest = (running_sum_next >= {{(SUM_W-DIST_W-1){1'b0}}, drop})
             ? running_sum_next - {{(SUM_W-DIST_W-1){1'b0}}, drop} : '0;
        case (mode)
          FUNC_MEAN3: res.distance_cm = div3(running_sum_next);
          FUNC_TRIM5: res.distance_cm = div3(rest);
          default:    res.distance_cm = sample_cm;
        endcase
        res.done_res    = 1'b1;
        res.busy_res    = 1'b0;
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end else begin
        tick_count_next = '0;
        phase_next      = (cfg.clear_us == '0) ? PH_TRIG : PH_CLEAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count   <= '0;
      pulse_cm     <= '0;
      pulse_frac   <= '0;
      sample_index <= '0;
      mode         <= FUNC_SINGLE;
      running_sum  <= '0;
      smallest     <= '0;
      largest      <= '0;
    end else if (step) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      pulse_cm     <= pulse_cm_next;
      pulse_frac   <= pulse_frac_next;
      sample_index <= sample_index_next;
      mode         <= mode_next;
      running_sum  <= running_sum_next;
      smallest     <= smallest_next;
      largest      <= largest_next;
    end
  end

endmodule

// ----- rtl/core/ultrasonic_ranger_trimmed_mean.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_ranger_trimmed_mean
// Ultrasonic ranger controller, one microsecond tick per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one item per microsecond tick with
//   start_req, func and the sampled echo_level.
//   Output channel (out_valid / out_stall): exactly one item per input item
//   with trigger_level, busy_res, done_res and distance_cm (0 unless done).
//   Config channel (cfg_valid / cfg_ready, always ready): cfg_index selects
//   timeout_us, trigger_us or clear_us; write only while no measurement runs.
// Timing:
//   An accepted item sits in the input register, is processed once the
//   output register is free or draining, and lands there. One item per
//   cycle sustained while out_stall is low: the sequencer steps once per
//   item and the input register refills in the cycle it drains.
// Reset: config registers return to their defaults, sequencer goes idle,
//   both holding registers empty.
// Stall: the output register holds its item; one more item waits in the
//   input register, after which in_stall rises.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_trimmed_mean (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            start_req,
  input  logic [urtm_pkg::FUNC_W-1:0]     func,
  input  logic                            echo_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            trigger_level,
  output logic                            busy_res,
  output logic                            done_res,
  output logic [urtm_pkg::DIST_W-1:0]     distance_cm,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [urtm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [urtm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import urtm_pkg::*;

  cfg_t              cfg;
  logic              in_full;
  logic              in_start;
  logic [FUNC_W-1:0] in_func;
  logic              in_echo;
  logic              advance;
  logic              accept_in;
  result_t           res;

  assign cfg_ready = 1'b1;
  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;
  assign accept_in = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_us <= TIMEOUT_RST;
      cfg.trigger_us <= TRIGGER_RST;
      cfg.clear_us   <= CLEAR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TIMEOUT: cfg.timeout_us <= cfg_data[TICK_W-1:0];
        REG_TRIGGER: cfg.trigger_us <= cfg_data[TRIG_W-1:0];
        REG_CLEAR:   cfg.clear_us   <= cfg_data[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // input holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept_in) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      in_start <= start_req;
      in_func  <= func;
      in_echo  <= echo_level;
    end
  end

  urtm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .start_req  (in_start),
    .func       (in_func),
    .echo_level (in_echo),
    .cfg        (cfg),
    .res        (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      trigger_level <= res.trigger_level;
      busy_res      <= res.busy_res;
      done_res      <= res.done_res;
      distance_cm   <= res.distance_cm;
    end
  end

  a_in_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output is free");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(busy_res && done_res))
    else $error("busy and done on the same item");

  a_dist_only_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !done_res) |-> (distance_cm == '0))
    else $error("distance nonzero without done");

  a_trig_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && trigger_level) |-> busy_res)
    else $error("trigger high outside a measurement");

endmodule

// ----- dv/ultrasonic_ranger_trimmed_mean_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ultrasonic_ranger_trimmed_mean_tb
// Tick-level check of the ranger: trigger timing, echo timing and all three
// averaging modes. A cycle-true predictor shadows the sequencer. Every output
// item is compared with it, field by field. The echo is generated from the
// predicted phase: a pulse or missing edge, with directed or random lead-in,
// width and stale-high prefix. Both channels get random gaps.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_trimmed_mean_tb;
  import urtm_pkg::*;

  localparam int TICK_TARGET    = 1350;
  localparam int CYCLE_LIMIT    = 500000;
  // selector value with no mode of its own
  localparam logic [FUNC_W-1:0] FUNC_SPARE = FUNC_W'(3);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic start_req = 1'b0;
  logic [FUNC_W-1:0] func = FUNC_SINGLE;
  logic echo_level = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic trigger_level;
  logic busy_res;
  logic done_res;
  logic [DIST_W-1:0] distance_cm;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TIMEOUT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  ultrasonic_ranger_trimmed_mean uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .start_req     (start_req),
    .func          (func),
    .echo_level    (echo_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .trigger_level (trigger_level),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .distance_cm   (distance_cm),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // ---- ranger shadow state ----
  cfg_t              cfg_m;
  phase_t            ph;
  logic [TICK_W-1:0] tick_n;
  logic [TICK_W-1:0] pulse_n;
  logic [IDX_W-1:0]  sample_n;
  logic [FUNC_W-1:0] mode_m;
  logic [SUM_W-1:0]  sum_cm;
  logic [DIST_W-1:0] min_cm;
  logic [DIST_W-1:0] max_cm;
  result_t           pending[$];

  int pinned_cm = -1;   // typed-in distance for the current directed shot
  int ticks_sent = 0;
  int readings = 0;
  int zero_hits = 0;
  int mode_hits[3] = '{0, 0, 0};
  int settings_written = 0;
  int fails = 0;
  int feed_pct = 0;
  int sink_pct = 0;

  // echo waveform of one sample, in ticks from the first echo-phase tick
  int plan_stale;
  int plan_gap;
  int plan_hi;

  typedef struct packed {
    logic [TICK_W-1:0] tmo;
    logic [TRIG_W-1:0] trg;
    logic [TRIG_W-1:0] clr;
    logic [FUNC_W-1:0] fn;
    int                stale;
    int                gap;
    int                hi;
    int                cm;
  } shot_t;

  shot_t shots[$];

  function automatic shot_t shot(input logic [TICK_W-1:0] tmo, input logic [TRIG_W-1:0] trg,
                                 input logic [TRIG_W-1:0] clr, input logic [FUNC_W-1:0] fn,
                                 input int stale, input int gap, input int hi, input int cm);
    shot_t s;
    s.tmo = tmo;
    s.trg = trg;
    s.clr = clr;
    s.fn = fn;
    s.stale = stale;
    s.gap = gap;
    s.hi = hi;
    s.cm = cm;
    return s;
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic void new_plan();
    plan_stale = ($urandom_range(3) == 0) ? $urandom_range(10, 1) : 0;
    plan_gap = $urandom_range(12, 1);
    plan_hi = ($urandom_range(9) == 0) ? $urandom_range(240, 100) : $urandom_range(100, 1);
    // a missing edge waits for the timeout, so only when that is short
    if (cfg_m.timeout_us <= 300) begin
      if ($urandom_range(9) == 0) plan_hi = 0;
      if ($urandom_range(9) == 0) plan_gap = 0;
    end
  endfunction

  function automatic void next_sample();
    tick_n = '0;
    ph = (cfg_m.clear_us == '0) ? PH_TRIG : PH_CLEAR;
  endfunction

  // advance the shadow by one tick and queue the output item it yields
  function automatic void ranger_step(input logic s, input logic [FUNC_W-1:0] f,
                                      input logic e);
    result_t           r;
    logic              fin;
    logic [TICK_W-1:0] pulse;
    logic [DIST_W-1:0] cm;
    logic [IDX_W-1:0]  need;
    logic [SUM_W-1:0]  rest;
    r = '0;
    r.busy_res = 1'b1;
    fin = 1'b0;
    pulse = '0;
    cm = '0;
    rest = '0;
    case (ph)
      PH_CLEAR: begin
        tick_n = tick_n + TICK_W'(1);
        if (tick_n >= TICK_W'(cfg_m.clear_us)) begin
          tick_n = '0;
          ph = PH_TRIG;
        end
      end
      PH_TRIG: begin
        r.trigger_level = 1'b1;
        tick_n = tick_n + TICK_W'(1);
        if (tick_n >= TICK_W'(cfg_m.trigger_us)) begin
          tick_n = '0;
          ph = PH_WAIT_LOW;
        end
      end
      PH_WAIT_LOW, PH_WAIT_RISE, PH_HIGH: begin
        if (ph == PH_WAIT_LOW) begin
          if (!e) ph = PH_WAIT_RISE;
        end else if (ph == PH_WAIT_RISE) begin
          if (e) begin
            ph = PH_HIGH;
            pulse_n = TICK_W'(1);
          end
        end else if (e) begin
          pulse_n = pulse_n + TICK_W'(1);
        end else begin
          fin = 1'b1;
          pulse = pulse_n;
        end
        // timeout runs over all three echo phases
        if (!fin) begin
          tick_n = tick_n + TICK_W'(1);
          if (tick_n >= cfg_m.timeout_us) begin
            fin = 1'b1;
            pulse = '0;
          end
        end
      end
      default: begin
        r.busy_res = 1'b0;
        ph = PH_IDLE;
        if (s) begin
          r.busy_res = 1'b1;
          mode_m = (f == FUNC_MEAN3 || f == FUNC_TRIM5) ? f : FUNC_SINGLE;
          sample_n = '0;
          sum_cm = '0;
          min_cm = '0;
          max_cm = '0;
          pulse_n = '0;
          next_sample();
        end
      end
    endcase

    if (fin) begin
      cm = DIST_W'((64'(pulse) * 64'(CM_STEP)) / 64'(CM_BASE));
      if (sample_n == '0) begin
        min_cm = cm;
        max_cm = cm;
      end else begin
        if (cm > max_cm) max_cm = cm;
        if (cm < min_cm) min_cm = cm;
      end
      sum_cm = sum_cm + SUM_W'(cm);
      sample_n = sample_n + IDX_W'(1);
      need = (mode_m == FUNC_MEAN3) ? SAMPLES_MEAN3 :
             (mode_m == FUNC_TRIM5) ? SAMPLES_TRIM5 : SAMPLES_SINGLE;
      if (sample_n >= need) begin
        if (mode_m == FUNC_MEAN3) begin
          r.distance_cm = DIST_W'(sum_cm / 3);
        end else if (mode_m == FUNC_TRIM5) begin
          rest = SUM_W'(max_cm) + SUM_W'(min_cm);
          rest = (sum_cm >= rest) ? sum_cm - rest : '0;
          r.distance_cm = DIST_W'(rest / 3);
        end else begin
          r.distance_cm = cm;
        end
        readings++;
        mode_hits[mode_m]++;
        if (r.distance_cm == '0) zero_hits++;
        if (pinned_cm >= 0) r.distance_cm = DIST_W'(pinned_cm);
        r.done_res = 1'b1;
        r.busy_res = 1'b0;
        ph = PH_IDLE;
        tick_n = '0;
      end else begin
        next_sample();
      end
    end
    pending.push_back(r);
  endfunction

  // ---- drivers; every task starts and ends just after a falling edge ----
  task automatic send_tick(input logic s, input logic [FUNC_W-1:0] f, input logic e);
    int gap;
    gap = ($urandom_range(99) < feed_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    start_req <= s;
    func <= f;
    echo_level <= e;
    do @(posedge clk); while (in_stall);
    ranger_step(s, f, e);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TIMEOUT: cfg_m.timeout_us = data;
      REG_TRIGGER: cfg_m.trigger_us = data[TRIG_W-1:0];
      REG_CLEAR:   cfg_m.clear_us = data[TRIG_W-1:0];
      default: ;
    endcase
    settings_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [TICK_W-1:0] tmo, input logic [TRIG_W-1:0] trg,
                                input logic [TRIG_W-1:0] clr);
    if (tmo == cfg_m.timeout_us && trg == cfg_m.trigger_us && clr == cfg_m.clear_us) return;
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);   // input and output registers drain
    @(negedge clk);
    if (tmo != cfg_m.timeout_us) write_reg(REG_TIMEOUT, tmo);
    if (trg != cfg_m.trigger_us) write_reg(REG_TRIGGER, CFG_DATA_W'(trg));
    if (clr != cfg_m.clear_us) write_reg(REG_CLEAR, CFG_DATA_W'(clr));
  endtask

  // one measurement from the start tick to the done tick, then a few idle ticks
  task automatic run_shot(input logic [FUNC_W-1:0] fn, input logic noisy);
    int   k;
    logic e;
    k = 0;
    send_tick(1'b1, fn, noisy & 1'($urandom));
    while (ph != PH_IDLE) begin
      if (ph == PH_WAIT_LOW || ph == PH_WAIT_RISE || ph == PH_HIGH) begin
        e = (k < plan_stale) ||
            (k >= plan_stale + plan_gap && k < plan_stale + plan_gap + plan_hi);
        k++;
      end else begin
        if (k != 0 && noisy) new_plan();
        k = 0;
        e = noisy & 1'($urandom);
      end
      // requests and selector changes while busy must be ignored
      send_tick(noisy & ($urandom_range(3) == 0), noisy ? FUNC_W'($urandom) : fn, e);
    end
    repeat (noisy ? $urandom_range(4) : 1)
      send_tick(1'b0, FUNC_W'($urandom), noisy & 1'($urandom));
  endtask

  // ---- output side ----
  always @(negedge clk) begin : sink_stall
    int stall_left;
    if (stall_left == 0 && $urandom_range(99) < sink_pct) stall_left = pick_gap();
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      fails++;
      if (fails <= 30)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch_out
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        fails++;
        if (fails <= 30)
          $display("%0t: unexpected item, expected none, got trig %0b busy %0b done %0b cm %0d",
                   $time, trigger_level, busy_res, done_res, distance_cm);
      end else begin
        want = pending.pop_front();
        check_field("trigger_level", 32'(want.trigger_level), 32'(trigger_level));
        check_field("busy_res", 32'(want.busy_res), 32'(busy_res));
        check_field("done_res", 32'(want.done_res), 32'(done_res));
        check_field("distance_cm", 32'(want.distance_cm), 32'(distance_cm));
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int shot_no;
    cfg_m.timeout_us = TIMEOUT_RST;
    cfg_m.trigger_us = TRIGGER_RST;
    cfg_m.clear_us = CLEAR_RST;
    ph = PH_IDLE;
    tick_n = '0;
    pulse_n = '0;
    sample_n = '0;
    mode_m = FUNC_SINGLE;
    sum_cm = '0;
    min_cm = '0;
    max_cm = '0;

    // timeout, trigger, clear, mode, stale, gap, width, expected cm
    shots.push_back(shot(TIMEOUT_RST, TRIGGER_RST, CLEAR_RST, FUNC_SINGLE, 0, 5, 59, 1));
    shots.push_back(shot(TIMEOUT_RST, TRIGGER_RST, CLEAR_RST, FUNC_SINGLE, 0, 3, 58, 0));
    shots.push_back(shot(TIMEOUT_RST, TRIGGER_RST, CLEAR_RST, FUNC_SPARE, 20, 3, 59, 1));
    shots.push_back(shot(TIMEOUT_RST, 8'd1, 8'd0, FUNC_MEAN3, 0, 2, 59, 1));
    shots.push_back(shot(TIMEOUT_RST, 8'd0, 8'd1, FUNC_SINGLE, 0, 1, 59, 1));
    shots.push_back(shot(20'd50, TRIGGER_RST, CLEAR_RST, FUNC_SINGLE, 0, 10, 100, 0));
    shots.push_back(shot(20'd40, TRIGGER_RST, CLEAR_RST, FUNC_SINGLE, 60, 1, 5, 0));
    shots.push_back(shot(20'd1, TRIGGER_RST, CLEAR_RST, FUNC_TRIM5, 0, 1, 5, 0));
    shots.push_back(shot(20'd0, TRIGGER_RST, CLEAR_RST, FUNC_MEAN3, 2, 1, 5, 0));
    shots.push_back(shot(20'hFFFFF, TRIGGER_RST, CLEAR_RST, FUNC_SINGLE, 0, 1, 59, 1));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (shots[i]) begin
      apply_settings(shots[i].tmo, shots[i].trg, shots[i].clr);
      feed_pct = pick_pct();
      sink_pct = pick_pct();
      plan_stale = shots[i].stale;
      plan_gap = shots[i].gap;
      plan_hi = shots[i].hi;
      pinned_cm = shots[i].cm;
      run_shot(shots[i].fn, 1'b0);
      pinned_cm = -1;
    end

    shot_no = 0;
    while (ticks_sent < TICK_TARGET) begin
      case (shot_no % 6)
        0: apply_settings(20'd300, 8'd1, 8'd0);
        1: apply_settings(TIMEOUT_RST, TRIGGER_RST, CLEAR_RST);
        2: apply_settings(20'd120, 8'd0, 8'd1);
        3: apply_settings(20'd0, 8'd3, 8'd2);
        4: apply_settings(20'hFFFFF, 8'd2, 8'd3);
        default: apply_settings(TICK_W'($urandom_range(400, 40)),
                                TRIG_W'($urandom_range(12)), TRIG_W'($urandom_range(6)));
      endcase
      feed_pct = pick_pct();
      sink_pct = pick_pct();
      new_plan();
      run_shot(FUNC_W'($urandom_range(3)), 1'b1);
      shot_no++;
    end

    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Ran %0d ticks: %0d readings (single %0d, mean-of-3 %0d, trimmed-5 %0d), %0d at 0 cm",
             ticks_sent, readings, mode_hits[0], mode_hits[1], mode_hits[2], zero_hits);
    $display("%0d register writes, %0d random measurements, %0d field mismatches",
             settings_written, shot_no, fails);
    if (fails == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
